[src/cpbm_pkg.sv]
// Shared types, codes and constants for the cartridge program-ROM bank mapper.
`default_nettype none

package cpbm_pkg;

  // Default number of bank-select bits
  localparam int BankBitsDefault = 4;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int BANK_W  = 4;
  localparam int SHIFT_W = 5;
  localparam int CFG_IDX_W = 2;

  // Restoring division over the 4-bit bank register, one bit per step
  localparam int DIV_STEPS = BANK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAPPER_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_COUNT  = 2'd1;

  // Mapper kinds
  localparam logic [KIND_W-1:0] KIND_FLAT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LATCH  = 2'd2;

  // Serial PRG modes, control bits 3..2
  localparam logic [1:0] MODE_PAIR_A      = 2'd0;
  localparam logic [1:0] MODE_PAIR_B      = 2'd1;
  localparam logic [1:0] MODE_FIXED_FIRST = 2'd2;
  localparam logic [1:0] MODE_FIXED_LAST  = 2'd3;

  // Input codes
  localparam logic OP_WRITE = 1'b0;

  // Serial register constants
  localparam logic [SHIFT_W-1:0] SHIFT_MARKER = 5'h10;
  localparam logic [SHIFT_W-1:0] CTRL_RESET   = 5'h0C;
  localparam logic [ADDR_W-1:0]  ADDR_CTRL_TOP  = 16'h9FFF;
  localparam logic [ADDR_W-1:0]  ADDR_BANK_BASE = 16'hE000;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // accept the input word, update mapper state
    logic step;      // one division step
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken
  } status_t;

endpackage

`default_nettype wire

[src/cpbm_ctrl.sv]
// Sequencer for the bank mapper: accept, divide steps, result hand-off.
`default_nettype none

module cpbm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cpbm_pkg::status_t status,
  output cpbm_pkg::cmd_t        cmd
);
  import cpbm_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start     = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencing checks
  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_DIVIDE)
    else $error("accepted word did not enter the divide phase");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && step_cnt == LAST_STEP) |=> state == ST_FINISH)
    else $error("divide phase did not end after the last step");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !status.out_free) |=> state == ST_FINISH)
    else $error("result dropped while output register was full");

endmodule

`default_nettype wire

[src/cpbm_datapath.sv]
// Mapper registers, bank modulo divider and output register.
`default_nettype none

module cpbm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cpbm_pkg::cmd_t                cmd,
  output cpbm_pkg::status_t                  status,
  input  wire logic                          cfg_write,
  input  wire logic [cpbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpbm_pkg::COUNT_W-1:0]  cfg_data,
  input  wire logic                          op,
  input  wire logic [cpbm_pkg::ADDR_W-1:0]   addr,
  input  wire logic [cpbm_pkg::DATA_W-1:0]   wdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cpbm_pkg::BANK_W-1:0]        low_window_bank,
  output logic [cpbm_pkg::BANK_W-1:0]        high_window_bank,
  output logic                               banked
);
  import cpbm_pkg::*;

  localparam int                 LIM  = 1 << BankBitsDefault;
  localparam logic [COUNT_W-1:0] MASK = COUNT_W'(LIM - 1);

  // Configuration
  logic [KIND_W-1:0]  mapper_kind;
  logic [COUNT_W-1:0] bank_count;

  // Mapper state
  logic [SHIFT_W-1:0] serial_shift, serial_shift_next;
  logic [SHIFT_W-1:0] serial_control, serial_control_next;
  logic [BANK_W-1:0]  serial_bank, serial_bank_next;
  logic [BANK_W-1:0]  latch_bank, latch_bank_next;

  // Divider
  logic [BANK_W-1:0]  dvd;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W-1:0] total;

  // Result
  logic [COUNT_W-1:0] lo, hi, lo_inc;
  logic               banked_val;
  logic [1:0]         mode;
  logic [SHIFT_W-1:0] shifted;

  // Effective bank count: zero reads as one, saturate at the bank-select range
  always_comb begin
    total = bank_count;
    if (total == '0) total = COUNT_W'(1);
    if (32'(total) > LIM) total = COUNT_W'(LIM);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind <= KIND_FLAT;
      bank_count  <= COUNT_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == REG_MAPPER_KIND) mapper_kind <= cfg_data[KIND_W-1:0];
      if (cfg_index == REG_BANK_COUNT)  bank_count  <= cfg_data;
    end
  end

  // Cartridge register writes
  always_comb begin
    serial_shift_next   = serial_shift;
    serial_control_next = serial_control;
    serial_bank_next    = serial_bank;
    latch_bank_next     = latch_bank;
    shifted             = {wdata[0], serial_shift[SHIFT_W-1:1]};
    if (op == OP_WRITE && addr[ADDR_W-1]) begin
      if (mapper_kind == KIND_SERIAL) begin
        if (wdata[7]) begin
          serial_shift_next   = SHIFT_MARKER;
          serial_control_next = serial_control | CTRL_RESET;
        end else if (serial_shift[0]) begin
          // fifth write commits the shifted value; $A000-$DFFF discards it
          if (addr <= ADDR_CTRL_TOP) begin
            serial_control_next = shifted;
          end else if (addr >= ADDR_BANK_BASE) begin
            serial_bank_next = shifted[BANK_W-1:0];
          end
          serial_shift_next = SHIFT_MARKER;
        end else begin
          serial_shift_next = shifted;
        end
      end else if (mapper_kind == KIND_LATCH) begin
        latch_bank_next = wdata[BANK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_shift   <= SHIFT_MARKER;
      serial_control <= CTRL_RESET;
      serial_bank    <= '0;
      latch_bank     <= '0;
    end else if (cmd.start) begin
      serial_shift   <= serial_shift_next;
      serial_control <= serial_control_next;
      serial_bank    <= serial_bank_next;
      latch_bank     <= latch_bank_next;
    end
  end

  // Restoring divider: bank register mod total, one dividend bit per step
  assign trial = {rem, dvd[BANK_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= (mapper_kind == KIND_LATCH) ? latch_bank_next : serial_bank_next;
      rem <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[BANK_W-2:0], 1'b0};
      if (trial >= {1'b0, total}) begin
        rem <= COUNT_W'(trial - {1'b0, total});
      end else begin
        rem <= trial[COUNT_W-1:0];
      end
    end
  end

  // Window banks from the reduced bank
  assign mode   = serial_control[3:2];
  assign lo_inc = (rem & ~COUNT_W'(1)) + COUNT_W'(1);

  always_comb begin
    lo         = '0;
    hi         = '0;
    banked_val = 1'b0;
    case (mapper_kind)
      KIND_SERIAL: begin
        banked_val = 1'b1;
        case (mode) inside
          MODE_PAIR_A, MODE_PAIR_B: begin
            lo = rem & ~COUNT_W'(1);
            hi = (lo_inc == total) ? '0 : lo_inc;
          end
          MODE_FIXED_FIRST: begin
            lo = '0;
            hi = rem;
          end
          default: begin
            lo = rem;
            hi = total - COUNT_W'(1);
          end
        endcase
      end
      KIND_LATCH: begin
        banked_val = 1'b1;
        lo         = rem;
        hi         = total - COUNT_W'(1);
      end
      default: begin
        banked_val = 1'b0;
      end
    endcase
  end

  // Output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      low_window_bank  <= BANK_W'(lo & MASK);
      high_window_bank <= BANK_W'(hi & MASK);
      banked           <= banked_val;
    end
  end

  // Datapath checks
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> rem < total)
    else $error("bank remainder not below bank count");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_flat_unbanked: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && mapper_kind != KIND_SERIAL && mapper_kind != KIND_LATCH)
      |=> !banked && low_window_bank == '0 && high_window_bank == '0)
    else $error("flat kind reported a banked mapping");

endmodule

`default_nettype wire

[src/cartridge_prg_bank_mapper.sv]
// Top level of the cartridge program-ROM bank mapper.
//
// Usage: each input word (op, addr, wdata) is a CPU write or a refresh
// request; each one yields exactly one result word with the 16 KB banks of
// the lower ($8000) and upper ($C000) windows and the banked flag.
// Both channels move a word when valid is high and stall is low.
// Configuration (mapper_kind at index 0, bank_count at index 1) is written
// through cfg_write/cfg_index/cfg_data while no word is in flight.
// An accepted word runs through the divide phase and then the output
// register, and no new word is taken until its result is loaded. The pace
// is set by the bank modulo, a restoring divider that takes one bit of the
// 4-bit bank per cycle, plus an accept step and an output load step.
// in_stall is low only while the sequencer is idle; a new word is taken
// while an earlier result still waits in the output register.
// When the receiver stalls, the result holds; a finished result behind it
// waits in the datapath and the input stays stalled until it moves.
// Reset (synchronous, rst high) sets the flat kind, a bank count of one,
// the serial shift register to its marker and control to fixed-last mode.
`default_nettype none

module cartridge_prg_bank_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [cpbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpbm_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           op,
  input  wire logic [cpbm_pkg::ADDR_W-1:0]    addr,
  input  wire logic [cpbm_pkg::DATA_W-1:0]    wdata,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cpbm_pkg::BANK_W-1:0]         low_window_bank,
  output logic [cpbm_pkg::BANK_W-1:0]         high_window_bank,
  output logic                                banked
);
  import cpbm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  cpbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, divider and output stage
  cpbm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .op               (op),
    .addr             (addr),
    .wdata            (wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .low_window_bank  (low_window_bank),
    .high_window_bank (high_window_bank),
    .banked           (banked)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the cartridge program-ROM bank mapper.
`timescale 1ns / 1ps

module tb_top;
  import cpbm_pkg::*;

  // Codes that the package does not name
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic              OP_REFRESH  = 1'b1;
  localparam logic [DATA_W-1:0] SERIAL_CLEAR = 8'h80;

  localparam int BANK_LIMIT     = 1 << BankBitsDefault;
  localparam int MAPPER_LATENCY = 6;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_WORDS   = 1250;

  typedef struct packed {
    logic [BANK_W-1:0] low;
    logic [BANK_W-1:0] high;
    logic              bnk;
  } bank_map_t;

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAPPER_KIND;
  logic [COUNT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 op = OP_WRITE;
  logic [ADDR_W-1:0]    addr = '0;
  logic [DATA_W-1:0]    wdata = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BANK_W-1:0]    low_window_bank;
  logic [BANK_W-1:0]    high_window_bank;
  logic                 banked;

  // Mapper state as the testbench tracks it
  logic [KIND_W-1:0]  model_kind = KIND_FLAT;
  logic [COUNT_W-1:0] model_count = 5'd1;
  logic [SHIFT_W-1:0] shift_reg = SHIFT_MARKER;
  logic [SHIFT_W-1:0] ctrl_reg = CTRL_RESET;
  logic [BANK_W-1:0]  serial_bank = '0;
  logic [BANK_W-1:0]  latch_bank = '0;

  bank_map_t pending_maps[$];
  int        errors = 0;
  int        words_sent = 0;
  int        quiet_cycles = 0;
  bit        tx_eager = 1'b0;
  bit        rx_eager = 1'b0;

  cartridge_prg_bank_mapper u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .addr             (addr),
    .wdata            (wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .low_window_bank  (low_window_bank),
    .high_window_bank (high_window_bank),
    .banked           (banked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one word to the tracked state and return the mapping it reports
  function automatic bank_map_t map_after_word(input logic o, input logic [ADDR_W-1:0] a,
                                               input logic [DATA_W-1:0] d);
    int unsigned total;
    int unsigned b;
    int unsigned lo;
    logic        fifth;
    bank_map_t   m;
    total = (model_count == 0) ? 1 : ((model_count > BANK_LIMIT) ? BANK_LIMIT : model_count);
    m = '0;
    // only writes in the cartridge space ($8000 and up) reach the registers
    if (o == OP_WRITE && a[ADDR_W-1]) begin
      if (model_kind == KIND_SERIAL) begin
        if (d[7]) begin
          shift_reg = SHIFT_MARKER;
          ctrl_reg = ctrl_reg | CTRL_RESET;
        end else begin
          fifth = shift_reg[0];
          shift_reg = {d[0], shift_reg[SHIFT_W-1:1]};
          if (fifth) begin
            if (a <= ADDR_CTRL_TOP) ctrl_reg = shift_reg;
            else if (a >= ADDR_BANK_BASE) serial_bank = shift_reg[BANK_W-1:0];
            shift_reg = SHIFT_MARKER;
          end
        end
      end else if (model_kind == KIND_LATCH) begin
        latch_bank = d[BANK_W-1:0];
      end
    end
    if (model_kind == KIND_SERIAL) begin
      b = serial_bank % total;
      m.bnk = 1'b1;
      case (ctrl_reg[3:2])
        MODE_FIXED_FIRST: begin
          m.low = '0;
          m.high = BANK_W'(b);
        end
        MODE_FIXED_LAST: begin
          m.low = BANK_W'(b);
          m.high = BANK_W'(total - 1);
        end
        default: begin
          // 32 KB pair: even bank low, next one high
          lo = {b[31:1], 1'b0};
          m.low = BANK_W'(lo);
          m.high = BANK_W'((lo + 1) % total);
        end
      endcase
    end else if (model_kind == KIND_LATCH) begin
      m.bnk = 1'b1;
      m.low = BANK_W'(latch_bank % total);
      m.high = BANK_W'(total - 1);
    end
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // Send one word after a random gap; the mapping is predicted at acceptance
  task automatic send_word(input logic o, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    addr <= a;
    wdata <= d;
    do @(posedge clk); while (in_stall);
    pending_maps.push_back(map_after_word(o, a, d));
    words_sent++;
  endtask

  // Hold the input off until every pending result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_maps.size() != 0);
  endtask

  task automatic set_config(input logic [KIND_W-1:0] k, input logic [COUNT_W-1:0] c);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_MAPPER_KIND;
    cfg_data <= COUNT_W'(k);
    @(posedge clk);
    model_kind = k;
    cfg_index <= REG_BANK_COUNT;
    cfg_data <= c;
    @(posedge clk);
    model_count = c;
    cfg_write <= 1'b0;
  endtask

  // Five serial writes carrying a 5-bit value, LSB first; bits 6..1 are noise
  task automatic load_serial(input logic [ADDR_W-1:0] a, input logic [SHIFT_W-1:0] value);
    for (int i = 0; i < SHIFT_W; i++) begin
      send_word(OP_WRITE, a, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  function automatic logic [ADDR_W-1:0] serial_addr();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return ADDR_W'($urandom_range(16'h8000, 16'h9FFF));
    if (pick < 8) return ADDR_W'($urandom_range(16'hE000, 16'hFFFF));
    return ADDR_W'($urandom_range(16'hA000, 16'hDFFF));
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    bank_map_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("result word with nothing pending",
                        16'({low_window_bank, high_window_bank, banked}), 16'(0));
      end else begin
        want = pending_maps.pop_front();
        if (low_window_bank !== want.low)
          report_mismatch("low_window_bank", 16'(low_window_bank), 16'(want.low));
        if (high_window_bank !== want.high)
          report_mismatch("high_window_bank", 16'(high_window_bank), 16'(want.high));
        if (banked !== want.bnk)
          report_mismatch("banked", 16'(banked), 16'(want.bnk));
      end
    end
  end

  // Receiver: random stall before each result word
  initial begin : result_sink
    int hold;
    wait (!rst);
    forever begin
      hold = rx_eager ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Flat kind out of reset, then the unused kind with a saturating count
  task automatic test_reset_defaults();
    send_word(OP_REFRESH, 16'h0000, 8'h00);
    send_word(OP_WRITE, 16'hFFFF, 8'hFF);
    send_word(OP_WRITE, 16'h8000, SERIAL_CLEAR);
    set_config(KIND_UNUSED, 5'd31);
    send_word(OP_WRITE, 16'hFFFF, 8'h0F);
  endtask

  // Discrete latch: low nibble taken, writes below $8000 ignored, count edges
  task automatic test_latch_kind();
    set_config(KIND_LATCH, 5'd16);
    send_word(OP_WRITE, 16'h8000, 8'hFF);
    send_word(OP_WRITE, 16'h7FFF, 8'h03);
    send_word(OP_REFRESH, 16'hFFFF, 8'h0A);
    send_word(OP_WRITE, 16'hFFFF, 8'h00);
    set_config(KIND_LATCH, 5'd0);
    send_word(OP_WRITE, 16'hC000, 8'h0F);
    set_config(KIND_LATCH, 5'd5);
    send_word(OP_WRITE, 16'hBFFF, 8'h07);
  endtask

  // Serial: clear, control load, bank load, partial load cut by a clear
  task automatic test_serial_kind();
    set_config(KIND_SERIAL, 5'd16);
    send_word(OP_WRITE, 16'h8000, SERIAL_CLEAR);
    load_serial(16'h8000, 5'h00);
    load_serial(16'hE000, 5'h0B);
    send_word(OP_WRITE, 16'hFFFF, 8'h01);
    send_word(OP_WRITE, 16'hFFFF, 8'h00);
    send_word(OP_WRITE, 16'hE000, 8'hFF);
  endtask

  // Phases of random traffic, each under its own configuration
  task automatic test_random_traffic();
    int                 target;
    int                 phase;
    int                 phase_end;
    int                 roll;
    logic [KIND_W-1:0]  k;
    logic [COUNT_W-1:0] c;
    target = words_sent + RANDOM_WORDS;
    phase = 0;
    while (words_sent < target) begin
      case (phase)
        0: begin k = KIND_SERIAL; c = 5'd1;  end
        1: begin k = KIND_SERIAL; c = 5'd16; end
        2: begin k = KIND_LATCH;  c = 5'd31; end
        3: begin k = KIND_SERIAL; c = 5'd0;  end
        4: begin k = KIND_FLAT;   c = 5'd16; end
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 55) k = KIND_SERIAL;
          else if (roll < 80) k = KIND_LATCH;
          else if (roll < 90) k = KIND_FLAT;
          else k = KIND_UNUSED;
          c = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 31))
                                          : COUNT_W'($urandom_range(1, 16));
        end
      endcase
      set_config(k, c);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      phase_end = words_sent + $urandom_range(40, 120);
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_word(OP_WRITE, serial_addr(), {1'b1, 7'($urandom)});
        end else if (roll < 70) begin
          load_serial(serial_addr(), SHIFT_W'($urandom));
        end else if (roll < 72) begin
          // let the pipeline run dry mid-phase
          wait_for_results();
        end else begin
          send_word(1'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
        end
      end
      phase++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_latch_kind();
    test_serial_kind();
    test_random_traffic();
    wait_for_results();
    repeat (2 * MAPPER_LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cpbm_pkg.sv
src/cpbm_ctrl.sv
src/cpbm_datapath.sv
src/cartridge_prg_bank_mapper.sv
tb/sv/tb_top.sv
